// ===== rtl/core/i2ccds_pkg.sv =====
// Shared constants and the serial clock divider table for the divider search.
// No dependencies; used by i2ccds_divider and i2c_clock_divider_search.
package i2ccds_pkg;

  localparam int RATE_W    = 27;  // bus clock and achieved rate width
  localparam int REQ_W     = 24;  // requested rate width
  localparam int TDIV_W    = 12;  // table entries reach 3840
  localparam int DIVISOR_W = 14;  // table entry times multiplier (up to 4)
  localparam int STEPS     = RATE_W;
  localparam int CNT_W     = $clog2(STEPS);
  localparam int IDX_W     = 6;
  localparam int CODE_W    = 2;

  localparam logic [RATE_W-1:0]  BUS_CLOCK_RESET = 27'd24000000;
  localparam logic [IDX_W-1:0]   PASS1_FIRST = 6'd16;
  localparam logic [IDX_W-1:0]   PASS1_LAST  = 6'd63;
  localparam logic [IDX_W-1:0]   PASS2_FIRST = 6'd0;
  localparam logic [IDX_W-1:0]   PASS2_LAST  = 6'd14;
  localparam logic [CODE_W-1:0]  CODE_LAST   = 2'd2;

  function automatic logic [TDIV_W-1:0] scl_div(input logic [IDX_W-1:0] idx);
    logic [TDIV_W-1:0] d;
    unique case (idx)
      6'd0:  d = 12'd20;   6'd1:  d = 12'd22;   6'd2:  d = 12'd24;   6'd3:  d = 12'd26;
      6'd4:  d = 12'd28;   6'd5:  d = 12'd30;   6'd6:  d = 12'd34;   6'd7:  d = 12'd40;
      6'd8:  d = 12'd28;   6'd9:  d = 12'd32;   6'd10: d = 12'd36;   6'd11: d = 12'd40;
      6'd12: d = 12'd44;   6'd13: d = 12'd48;   6'd14: d = 12'd56;   6'd15: d = 12'd68;
      6'd16: d = 12'd48;   6'd17: d = 12'd56;   6'd18: d = 12'd64;   6'd19: d = 12'd72;
      6'd20: d = 12'd80;   6'd21: d = 12'd88;   6'd22: d = 12'd104;  6'd23: d = 12'd128;
      6'd24: d = 12'd80;   6'd25: d = 12'd96;   6'd26: d = 12'd112;  6'd27: d = 12'd128;
      6'd28: d = 12'd144;  6'd29: d = 12'd160;  6'd30: d = 12'd192;  6'd31: d = 12'd240;
      6'd32: d = 12'd160;  6'd33: d = 12'd192;  6'd34: d = 12'd224;  6'd35: d = 12'd256;
      6'd36: d = 12'd288;  6'd37: d = 12'd320;  6'd38: d = 12'd384;  6'd39: d = 12'd480;
      6'd40: d = 12'd320;  6'd41: d = 12'd384;  6'd42: d = 12'd448;  6'd43: d = 12'd512;
      6'd44: d = 12'd576;  6'd45: d = 12'd640;  6'd46: d = 12'd768;  6'd47: d = 12'd960;
      6'd48: d = 12'd640;  6'd49: d = 12'd768;  6'd50: d = 12'd896;  6'd51: d = 12'd1024;
      6'd52: d = 12'd1152; 6'd53: d = 12'd1280; 6'd54: d = 12'd1536; 6'd55: d = 12'd1920;
      6'd56: d = 12'd1280; 6'd57: d = 12'd1536; 6'd58: d = 12'd1792; 6'd59: d = 12'd2048;
      6'd60: d = 12'd2304; 6'd61: d = 12'd2560; 6'd62: d = 12'd3072; 6'd63: d = 12'd3840;
      default: d = 12'd20;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/i2ccds_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by every candidate.
// Depends on i2ccds_pkg for widths.
module i2ccds_divider import i2ccds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RATE_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [RATE_W-1:0]    quotient
);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [RATE_W-1:0]    qsh;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;

  assign trial = {rem, qsh[RATE_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      qsh <= dividend;
    end else if (busy) begin
      if (diff[DIVISOR_W]) begin
        rem <= trial[DIVISOR_W-1:0];
        qsh <= {qsh[RATE_W-2:0], 1'b0};
      end else begin
        rem <= diff[DIVISOR_W-1:0];
        qsh <= {qsh[RATE_W-2:0], 1'b1};
      end
    end
  end

  assign quotient = qsh;

endmodule

// ===== rtl/core/i2c_clock_divider_search.sv =====
// Serial clock divider search: walks the divider table through a shared divider.
// Each candidate is issued, run through 27 divide steps and evaluated; 144 candidates
// in pass one, 45 more when pass two runs, plus one check state per pass; a hit ends
// the pass early. One item at a time; busy is high meanwhile.
// done pulses one cycle with the result; a new start is taken in that same cycle.
// Synchronous reset returns to idle and sets bus_clock_hz to 24000000.
module i2c_clock_divider_search import i2ccds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  requested_rate,
  output logic              done,
  output logic              found,
  output logic [7:0]        divider_setting,
  output logic [RATE_W-1:0] achieved_rate,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0]        state;
  logic [RATE_W-1:0] bus_clock_hz;
  logic [REQ_W-1:0]  req;
  logic              pass2;
  logic [CODE_W-1:0] code;
  logic [IDX_W-1:0]  idx;
  logic [RATE_W-1:0] best_rate;
  logic [CODE_W-1:0] best_code;
  logic [IDX_W-1:0]  best_idx;

  logic                 div_start;
  logic                 div_done;
  logic [RATE_W-1:0]    div_quot;
  logic [DIVISOR_W-1:0] divisor;
  logic [RATE_W-1:0]    req_ext;
  logic                 is_hit;
  logic                 is_better;
  logic                 idx_last;
  logic [31:0]          best_p1;
  logic [31:0]          lhs10;
  logic [31:0]          rhs9;
  logic                 need_pass2;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {5'd0, bus_clock_hz} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz <= BUS_CLOCK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      bus_clock_hz <= pwdata[RATE_W-1:0];
    end
  end

  assign divisor   = DIVISOR_W'({2'b00, scl_div(idx)} << code);
  assign div_start = (state == ST_ISSUE);
  assign busy      = (state != ST_IDLE);

  i2ccds_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bus_clock_hz),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign req_ext   = {3'd0, req};
  assign is_hit    = (div_quot == req_ext);
  assign is_better = (div_quot < req_ext) && (div_quot > best_rate);
  assign idx_last  = pass2 ? (idx == PASS2_LAST) : (idx == PASS1_LAST);

  // best < floor(req*9/10)  <=>  10*(best+1) <= 9*req
  assign best_p1    = {5'd0, best_rate} + 32'd1;
  assign lhs10      = (best_p1 << 3) + (best_p1 << 1);
  assign rhs9       = ({8'd0, req} << 3) + {8'd0, req};
  assign need_pass2 = !pass2 && (lhs10 <= rhs9);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            if (is_hit || (idx_last && code == CODE_LAST)) begin
              state <= ST_CHECK;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_CHECK: begin
          if (need_pass2) begin
            state <= ST_ISSUE;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req       <= requested_rate;
          pass2     <= 1'b0;
          code      <= '0;
          idx       <= PASS1_FIRST;
          best_rate <= '0;
          best_code <= '0;
          best_idx  <= '0;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          if (is_hit || is_better) begin
            best_rate <= div_quot;
            best_code <= code;
            best_idx  <= idx;
          end
          if (idx_last) begin
            code <= code + 1'b1;
            idx  <= pass2 ? PASS2_FIRST : PASS1_FIRST;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (need_pass2) begin
          pass2 <= 1'b1;
          code  <= '0;
          idx   <= PASS2_FIRST;
        end else begin
          found           <= (best_rate != '0);
          divider_setting <= (best_rate != '0) ? {best_code, best_idx} : 8'd0;
          achieved_rate   <= best_rate;
        end
      end
      default: ;
    endcase
  end

endmodule
